FILE: hw/rtl/swmv_pkg.sv
`timescale 1ns / 1ps

package swmv_pkg;

   // Configuration port geometry: 32-bit registers at byte address 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = '0;

   // Fractional bits of the mean and variance results
   localparam int FRAC_BITS = 8;

   // Window size after reset
   localparam int SIZE_RESET = 16;

endpackage

FILE: hw/rtl/sliding_window_mean_variance_unit.sv
`timescale 1ns / 1ps

// Sliding-window mean and sample variance.
// Input channel req_* carries one signed sample per transfer; output channel rsp_* returns
// one result per sample: the count of samples in the window, the mean (signed, 8 fraction
// bits) and the sample variance (unsigned, 8 fraction bits, zero below two samples).
// The window holds the last window_size samples in a ring memory; an exact running sum and
// sum of squares are updated with one shared squarer, oldest sample out before newest in.
// Both quotients come from one shared radix-2 restoring divider, one quotient bit a cycle:
// SAMPLE_BITS+8 steps for the mean, 2*SAMPLE_BITS+7 steps for the variance.
// The variance division is skipped when the variance is zero by rule (one sample, or a
// non-positive numerator). req_ready is high only in the idle state, so a new sample is
// accepted only after the sequencer has finished the previous one and returned to idle.
// A finished result sits in an output register: the next sample is accepted while it waits.
// If the receiver stalls with a result still held, the next result waits in the last
// sequencer state until the output register frees up.
// Reset empties the window and sets window_size to 16. Writing window_size (byte address 0
// on the csr_* port, 1..WINDOW_MAX, 0 acts as 1, larger values saturate, data bits above the
// count width are ignored) also empties it; write it only while no sample is in flight.
module sliding_window_mean_variance_unit
   import swmv_pkg::*;
#(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // sample input
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [SAMPLE_BITS-1:0]             req_sample,
   // result output
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [$clog2(WINDOW_MAX+1)-1:0]           rsp_sample_count,
   output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]   rsp_window_mean,
   output logic [2*SAMPLE_BITS+FRAC_BITS-2:0]        rsp_window_variance,
   // configuration
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]                     csr_paddr,
   input  logic [CSR_DATA_W-1:0]                     csr_pwdata,
   output logic [CSR_DATA_W-1:0]                     csr_prdata,
   output logic                                      csr_pready
);

   localparam int SB    = SAMPLE_BITS;
   localparam int CW    = $clog2(WINDOW_MAX + 1);       // count / window size
   localparam int PW    = $clog2(WINDOW_MAX);           // ring index
   localparam int LG    = $clog2(WINDOW_MAX);
   localparam int SUMW  = SB + LG + 1;                   // signed running sum
   localparam int SQW   = 2 * SB - 1 + LG;               // running sum of squares
   localparam int MW    = SB + FRAC_BITS;                // mean width
   localparam int VW    = 2 * SB + FRAC_BITS - 1;        // variance width
   localparam int DIFW  = CW + SQW;                      // n * sumsq
   localparam int BW    = 2 * SUMW;                      // sum squared
   localparam int CMPW  = (DIFW > BW) ? DIFW : BW;
   localparam int DW    = 2 * CW;                        // divisor width
   localparam int DVW   = DW + 1;                        // partial remainder width
   localparam int CNTW  = $clog2(VW + 1);
   localparam int SIZE_INIT = (SIZE_RESET > WINDOW_MAX) ? WINDOW_MAX : SIZE_RESET;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OLD,
      ST_NEW,
      ST_PREP,
      ST_SQR,
      ST_MDIV,
      ST_VLOAD,
      ST_VDIV,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           ws_ff, ws_in;
   logic [PW-1:0]           wpos_ff, wpos_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic signed [SUMW-1:0]  sum_ff, sum_in;
   logic [SQW-1:0]          sumsq_ff, sumsq_in;
   logic signed [SB-1:0]    x_ff, x_in;
   logic [SUMW-1:0]         mag_ff, mag_in;
   logic [DIFW-1:0]         a_ff, a_in;
   logic [BW-1:0]           b_ff, b_in;
   logic [DW-1:0]           vdvs_ff, vdvs_in;
   logic [DVW-1:0]          div_rem_ff, div_rem_in;
   logic [VW-1:0]           div_sh_ff, div_sh_in;
   logic [DW-1:0]           div_dvs_ff, div_dvs_in;
   logic [CNTW-1:0]         div_cnt_ff, div_cnt_in;
   logic [MW-1:0]           mean_ff, mean_in;
   logic [VW-1:0]           var_ff, var_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;
   logic [MW-1:0]           rsp_mean_ff, rsp_mean_in;
   logic [VW-1:0]           rsp_var_ff, rsp_var_in;

   // ring memory
   logic signed [SB-1:0]    ring [WINDOW_MAX];
   logic signed [SB-1:0]    ring_rd_ff;
   logic                    ring_we;

   // shared squarer
   logic signed [SB-1:0]    sq_op;
   logic signed [2*SB-1:0]  sq_prod;
   logic [SQW-1:0]          sq_val;

   // shared divider step
   logic [DVW-1:0]          div_shift;
   logic                    div_fit;
   logic [DVW-1:0]          div_rem_nx;
   logic [VW-1:0]           div_sh_nx;

   // misc combinational values
   logic                    full;
   logic                    wpos_last;
   logic [MW-1:0]           mean_q;
   logic [SUMW+FRAC_BITS-1:0] dvd_m;
   logic [CMPW-1:0]         a_ext;
   logic [CMPW-1:0]         b_ext;
   logic [DIFW-1:0]         diff;
   logic [DIFW+FRAC_BITS-1:0] dvd_v;
   logic                    csr_wr;
   logic [CW-1:0]           csr_size;

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_count    = rsp_count_ff;
   assign rsp_window_mean     = $signed(rsp_mean_ff);
   assign rsp_window_variance = rsp_var_ff;
   assign csr_pready          = 1'b1;
   assign csr_prdata          = CSR_DATA_W'(ws_ff);

   // Square the outgoing sample in ST_OLD, the incoming one otherwise
   assign sq_op   = (state_ff == ST_OLD) ? ring_rd_ff : x_ff;
   assign sq_prod = (2*SB)'(sq_op) * (2*SB)'(sq_op);
   assign sq_val  = SQW'($unsigned(sq_prod));

   // One restoring division step: shift in a dividend bit, subtract if it fits
   assign div_shift  = {div_rem_ff[DVW-2:0], div_sh_ff[VW-1]};
   assign div_fit    = (div_shift >= DVW'(div_dvs_ff));
   assign div_rem_nx = div_fit ? (div_shift - DVW'(div_dvs_ff)) : div_shift;
   assign div_sh_nx  = {div_sh_ff[VW-2:0], div_fit};

   assign full      = (fill_ff >= ws_ff);
   assign wpos_last = ((CW'(wpos_ff) + CW'(1)) == ws_ff);
   assign mean_q    = div_sh_nx[MW-1:0];
   assign dvd_m     = {mag_ff, {FRAC_BITS{1'b0}}};
   assign a_ext     = CMPW'(a_ff);
   assign b_ext     = CMPW'(b_ff);
   assign diff      = DIFW'(a_ext - b_ext);
   assign dvd_v     = {diff, {FRAC_BITS{1'b0}}};

   // Decode a configuration write and clamp the size to 1..WINDOW_MAX
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_size = csr_pwdata[CW-1:0];
      if (csr_size == '0) begin
         csr_size = CW'(1);
      end else if (csr_size > CW'(WINDOW_MAX)) begin
         csr_size = CW'(WINDOW_MAX);
      end
   end

   // Next-state and datapath
   always_comb begin
      state_in     = state_ff;
      ws_in        = ws_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      x_in         = x_ff;
      mag_in       = mag_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      vdvs_in      = vdvs_ff;
      div_rem_in   = div_rem_ff;
      div_sh_in    = div_sh_ff;
      div_dvs_in   = div_dvs_ff;
      div_cnt_in   = div_cnt_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      ring_we      = 1'b0;

      // drop the held result once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample;
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            // remove the oldest sample once the window is full
            if (full) begin
               sum_in   = sum_ff - SUMW'(ring_rd_ff);
               sumsq_in = sumsq_ff - sq_val;
            end
            state_in = ST_NEW;
         end
         ST_NEW: begin
            ring_we  = 1'b1;
            sum_in   = sum_ff + SUMW'(x_ff);
            sumsq_in = sumsq_ff + sq_val;
            wpos_in  = wpos_last ? '0 : (wpos_ff + PW'(1));
            fill_in  = full ? ws_ff : (fill_ff + CW'(1));
            state_in = ST_PREP;
         end
         ST_PREP: begin
            mag_in   = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
            a_in     = DIFW'(fill_ff) * DIFW'(sumsq_ff);
            state_in = ST_SQR;
         end
         ST_SQR: begin
            b_in       = BW'(mag_ff) * BW'(mag_ff);
            vdvs_in    = DW'(fill_ff) * DW'(fill_ff - CW'(1));
            // start the mean division: |sum| * 2^8 / n
            div_dvs_in = DW'(fill_ff);
            div_rem_in = DVW'(dvd_m >> MW);
            div_sh_in  = {dvd_m[MW-1:0], {(VW - MW){1'b0}}};
            div_cnt_in = CNTW'(MW);
            state_in   = ST_MDIV;
         end
         ST_MDIV: begin
            div_rem_in = div_rem_nx;
            div_sh_in  = div_sh_nx;
            div_cnt_in = div_cnt_ff - CNTW'(1);
            if (div_cnt_ff == CNTW'(1)) begin
               mean_in  = sum_ff[SUMW-1] ? (~mean_q + MW'(1)) : mean_q;
               state_in = ST_VLOAD;
            end
         end
         ST_VLOAD: begin
            // start the variance division or skip it when the result is zero
            if ((fill_ff >= CW'(2)) && (a_ext > b_ext)) begin
               div_dvs_in = vdvs_ff;
               div_rem_in = DVW'(dvd_v >> VW);
               div_sh_in  = VW'(dvd_v);
               div_cnt_in = CNTW'(VW);
               state_in   = ST_VDIV;
            end else begin
               var_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_VDIV: begin
            div_rem_in = div_rem_nx;
            div_sh_in  = div_sh_nx;
            div_cnt_in = div_cnt_ff - CNTW'(1);
            if (div_cnt_ff == CNTW'(1)) begin
               var_in   = div_sh_nx;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = fill_ff;
               rsp_mean_in  = mean_ff;
               rsp_var_in   = var_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // window size write empties the window
      if (csr_wr) begin
         unique case (csr_paddr[CSR_ADDR_W-1:2])
            REG_WINDOW_SIZE: begin
               ws_in    = csr_size;
               wpos_in  = '0;
               fill_in  = '0;
               sum_in   = '0;
               sumsq_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // State, window bookkeeping and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= CW'(SIZE_INIT);
         wpos_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      mag_ff       <= mag_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      vdvs_ff      <= vdvs_in;
      div_rem_ff   <= div_rem_in;
      div_sh_ff    <= div_sh_in;
      div_dvs_ff   <= div_dvs_in;
      div_cnt_ff   <= div_cnt_in;
      mean_ff      <= mean_in;
      var_ff       <= var_in;
      rsp_count_ff <= rsp_count_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_var_ff   <= rsp_var_in;
   end

   // Ring memory: write the new sample, read the slot at the write position
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[wpos_ff] <= x_ff;
      end
      ring_rd_ff <= ring[wpos_ff];
   end

   // Window bookkeeping stays in range
   assert property (@(posedge clock) disable iff (reset) fill_ff <= ws_ff)
      else $error("fill count exceeds window size");

   assert property (@(posedge clock) disable iff (reset) CW'(wpos_ff) < ws_ff)
      else $error("write position outside window");

   // Partial remainder stays below the divisor while dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MDIV || state_ff == ST_VDIV) |-> (div_rem_ff < DVW'(div_dvs_ff)))
      else $error("divider remainder not below divisor");

   // A transfer on the input starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_OLD))
      else $error("accepted sample did not start the sequence");

endmodule

FILE: dv/sliding_window_mean_variance_unit_test.sv
`timescale 1ns / 1ps

module sliding_window_mean_variance_unit_test;
   import swmv_pkg::*;

   localparam int SAMPLE_W      = 16;
   localparam int COUNT_W       = 9;
   localparam int MEAN_W        = SAMPLE_W + FRAC_BITS;
   localparam int VAR_W         = 2 * SAMPLE_W + FRAC_BITS - 1;
   localparam int HIST_DEPTH    = 256;
   localparam int HIST_IDX_W    = $clog2(HIST_DEPTH);
   localparam int RUN_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 1500;

   localparam logic signed [SAMPLE_W-1:0] SMPL_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SMPL_MIN = 16'sh8000;

   typedef struct {
      logic [COUNT_W-1:0]       count;
      logic signed [MEAN_W-1:0] mean;
      logic [VAR_W-1:0]         variance;
   } window_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [COUNT_W-1:0]           rsp_sample_count;
   logic signed [MEAN_W-1:0]     rsp_window_mean;
   logic [VAR_W-1:0]             rsp_window_variance;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_paddr = '0;
   logic [CSR_DATA_W-1:0]        csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   // Window model state
   logic signed [SAMPLE_W-1:0] sample_hist [HIST_DEPTH];
   int unsigned                window_len = SIZE_RESET;
   int unsigned                next_slot = 0;
   int unsigned                held_count = 0;
   longint                     window_sum = 0;
   longint unsigned            window_sumsq = 0;

   window_stats_type expected_stats [$];

   int          error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned holds_requested = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;

   sliding_window_mean_variance_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_window_mean     (rsp_window_mean),
      .rsp_window_variance (rsp_window_variance),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Push a sample into the window and compute count, mean and variance
   function automatic window_stats_type predict_stats(input logic signed [SAMPLE_W-1:0] value);
      window_stats_type stats;
      longint          x;
      longint          oldest;
      longint          mean_q8;
      longint unsigned n;
      longint unsigned scaled_sumsq;
      longint unsigned sum_squared;
      longint unsigned var_q8;
      int unsigned     slot;
      x = longint'(value);
      slot = next_slot % window_len;
      var_q8 = 0;
      // Evict the oldest sample once the window is full
      if (held_count >= window_len) begin
         oldest = longint'(sample_hist[slot[HIST_IDX_W-1:0]]);
         window_sum -= oldest;
         window_sumsq -= longint'(oldest * oldest);
         held_count = window_len - 1;
      end
      sample_hist[slot[HIST_IDX_W-1:0]] = value;
      window_sum += x;
      window_sumsq += longint'(x * x);
      next_slot = (slot + 1) % window_len;
      held_count++;
      n = 64'(held_count);
      mean_q8 = (window_sum * 256) / longint'(n);
      // Variance is zero below two samples and clamped at zero
      if (n >= 2) begin
         scaled_sumsq = n * window_sumsq;
         sum_squared = window_sum * window_sum;
         if (scaled_sumsq > sum_squared)
            var_q8 = ((scaled_sumsq - sum_squared) * 256) / (n * (n - 1));
      end
      stats.count = n[COUNT_W-1:0];
      stats.mean = mean_q8[MEAN_W-1:0];
      stats.variance = var_q8[VAR_W-1:0];
      return stats;
   endfunction

   // Compare one result transfer with the oldest prediction
   task automatic check_result();
      window_stats_type want;
      if (expected_stats.size() == 0) begin
         $display("%0t: result with none pending, expected none, actual count %0d",
                  $time, rsp_sample_count);
         error_count++;
      end else begin
         want = expected_stats.pop_front();
         if (rsp_sample_count !== want.count) begin
            $display("%0t: sample_count expected %0d actual %0d",
                     $time, want.count, rsp_sample_count);
            error_count++;
         end
         if (rsp_window_mean !== want.mean) begin
            $display("%0t: window_mean expected %0d actual %0d",
                     $time, want.mean, rsp_window_mean);
            error_count++;
         end
         if (rsp_window_variance !== want.variance) begin
            $display("%0t: window_variance expected %0d actual %0d",
                     $time, want.variance, rsp_window_variance);
            error_count++;
         end
      end
   endtask

   // Check result transfers and drive ready, with random stalls and long holds
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result();
      if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one sample, idling first at random; valid stays high after the transfer
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      expected_stats.push_back(predict_stats(value));
   endtask

   // Drop valid, wait for every pending result, then let the block go quiet
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_stats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write window_size over the configuration port; this also empties the window
   task automatic write_window_size(input logic [CSR_DATA_W-1:0] value);
      logic [COUNT_W-1:0] field;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_WINDOW_SIZE, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      field = value[COUNT_W-1:0];
      if (field == 0)
         window_len = 1;
      else if (field > HIST_DEPTH)
         window_len = HIST_DEPTH;
      else
         window_len = 32'(field);
      next_slot = 0;
      held_count = 0;
      window_sum = 0;
      window_sumsq = 0;
   endtask

   // Mostly full-range values, with extremes and small values mixed in
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         case ($urandom_range(3))
            0: return SMPL_MAX;
            1: return SMPL_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if (roll < 25)
         return SAMPLE_W'(int'($urandom_range(8)) - 4);
      return SAMPLE_W'($urandom());
   endfunction

   // Window of 16 after reset: first sample, extremes and alternating bits
   task automatic test_reset_window();
      send_sample('0);
      send_sample(SMPL_MAX);
      send_sample(SMPL_MIN);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      drain_results();
   endtask

   // Window size zero acts as one: count stays at one, variance zero
   task automatic test_window_zero();
      write_window_size(0);
      send_sample(SMPL_MAX);
      send_sample(SMPL_MIN);
      send_sample(16'sd5);
      drain_results();
   endtask

   // Window of two: equal samples, widest spread, wraparound
   task automatic test_window_two();
      write_window_size(2);
      send_sample(SMPL_MIN);
      send_sample(SMPL_MIN);
      send_sample(SMPL_MAX);
      send_sample(SMPL_MAX);
      send_sample(SMPL_MIN);
      drain_results();
   endtask

   // Oversized window values saturate to the ring depth
   task automatic test_window_saturation();
      write_window_size(300);
      send_sample(SMPL_MAX);
      send_sample(16'sh1234);
      send_sample(SMPL_MIN);
      drain_results();
      write_window_size(511);
      send_sample(-16'sd7);
      send_sample(16'sd9);
      drain_results();
   endtask

   // Random samples, sparse sender, heavily stalling receiver
   task automatic test_random_slow_receiver();
      send_idle_pct = 30;
      recv_idle_pct = 83;
      write_window_size(5);
      repeat (200) send_sample(pick_sample());
      drain_results();
   endtask

   // Random samples, largest window filled and wrapped once, slow sender
   task automatic test_random_slow_sender();
      send_idle_pct = 83;
      recv_idle_pct = 30;
      write_window_size(HIST_DEPTH);
      repeat (300) send_sample(pick_sample());
      drain_results();
   endtask

   // Random samples at full rate; long receiver holds back up the input
   task automatic test_random_backpressure();
      int unsigned sent;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // Upper data bits are ignored: this selects a window of three
      write_window_size(32'hFFFF_FE03);
      holds_requested++;
      for (sent = 0; sent < 200; sent++) begin
         if (sent == 120)
            holds_requested++;
         send_sample(pick_sample());
      end
      drain_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_window_zero();
      test_window_two();
      test_window_saturation();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_backpressure();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/swmv_pkg.sv
hw/rtl/sliding_window_mean_variance_unit.sv
dv/sliding_window_mean_variance_unit_test.sv
